### rtl/btha_pkg.sv
// ----------------------------------------------------------------------------
// btha_pkg
// Shared constants, codes and types of the boundary tag heap allocator.
// ----------------------------------------------------------------------------
package btha_pkg;

  localparam int unsigned HeapUnits     = 256;
  localparam int unsigned MinBlockUnits = 4;
  localparam int unsigned UW            = $clog2(HeapUnits);
  localparam int unsigned SW            = 24;
  localparam int unsigned IW            = SW + 1;
  localparam int unsigned NW            = 9;
  localparam int unsigned AW            = 10;

  localparam logic [7:0] TAG_FREE = 8'h55;
  localparam logic [7:0] TAG_USED = 8'haa;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADPTR  = 2'd2,
    ST_NOTUSED = 2'd3
  } status_e;

  typedef struct packed {
    logic          re;
    logic          we;
    logic [UW-1:0] addr;
    logic [31:0]   wdata;
  } mem_req_t;

  function automatic logic [31:0] mk_word(logic [7:0] tag, logic [SW-1:0] size);
    return {tag, size};
  endfunction

endpackage

### rtl/boundary_tag_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_unit
// Heap allocator with boundary tags, next-fit search and coalescing free.
// ----------------------------------------------------------------------------
// channel   direction  tdata                                     tuser
// s_axis    in         [9:0] request_bytes, [19:10] free_address  kind
// m_axis    out        [9:0] user_address, [11:10] status         -
//
// After reset a clearing pass writes the heap; no transfer is taken.
// A free or an allocate runs as a sequence of heap accesses; an allocate
// takes longer the more free blocks its search visits. All the accesses share
// the single heap memory port, one access per cycle.
// A finished result waits in the output register while the next item runs.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] request_bytes, [19:10] free_address
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [9:0] user_address, [11:10] status
);
  import btha_pkg::*;

  mem_req_t      mem_req;
  logic [31:0]   mem_rdata;
  logic          res_valid, res_ready;
  logic [AW-1:0] res_addr;
  status_e       res_status;
  logic          out_valid_q;
  logic [15:0]   out_data_q;

  btha_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  btha_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .kind_i          (s_axis_tuser),
    .request_bytes_i (s_axis_tdata[9:0]),
    .free_address_i  (s_axis_tdata[19:10]),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .user_address_o  (res_addr),
    .status_o        (res_status),
    .mem_req_o       (mem_req),
    .mem_rdata_i     (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= {4'd0, res_status, res_addr};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### rtl/btha_mem.sv
// ----------------------------------------------------------------------------
// btha_mem
// Heap word store: one port, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module btha_mem (
  input  logic                clk_i,
  input  btha_pkg::mem_req_t  req_i,
  output logic [31:0]         rdata_o
);
  import btha_pkg::*;

  logic [31:0] mem_q [HeapUnits];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/btha_ctrl.sv
// ----------------------------------------------------------------------------
// btha_ctrl
// Sequencer: next-fit search, carve, free checks, list edits and coalescing.
// ----------------------------------------------------------------------------
module btha_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [btha_pkg::AW-1:0]      request_bytes_i,
  input  logic [btha_pkg::AW-1:0]      free_address_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [btha_pkg::AW-1:0]      user_address_o,
  output btha_pkg::status_e            status_o,
  output btha_pkg::mem_req_t           mem_req_o,
  input  logic [31:0]                  mem_rdata_i
);
  import btha_pkg::*;

  typedef enum logic [5:0] {
    S_INIT, S_IDLE, S_DONE,
    S_A_SZ, S_A_NX, S_A_FIN, S_A_DEC, S_A_W1, S_A_W2, S_A_W3, S_A_T1, S_A_T2,
    S_F_1, S_F_2, S_F_3, S_F_4, S_F_5, S_F_6, S_F_7, S_F_8, S_F_9, S_F_10,
    S_CO0, S_CO1, S_CO2, S_CO3,
    S_CI0, S_CI1, S_CI2, S_CI3, S_CI4, S_CI5,
    S_M0, S_M1, S_M2, S_M3, S_M4
  } state_e;

  state_e        state_q, state_d, ret_q, ret_d;
  logic [UW-1:0] cnt_q, cnt_d, c_q, c_d, start_q, start_d, b_q, b_d;
  logic [UW-1:0] a_q, a_d, mb_q, mb_d, l_q, l_d, r_q, r_d, p_q, p_d, n_q, n_d;
  logic [UW-1:0] qs_q, qs_d, head_q, head_d, cursor_q, cursor_d;
  logic [SW-1:0] sz_q, sz_d, rest_q, rest_d, total_q, total_d;
  logic [NW-1:0] need_q, need_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [7:0]    ta_q, ta_d;
  logic [AW-1:0] addr_q, addr_d;
  status_e       st_q, st_d;
  logic          empty_q, empty_d, oob_q, oob_d;

  logic          rd_go, wr_go;
  logic [IW-1:0] ridx, widx;
  logic [31:0]   wdat, rd;
  logic [7:0]    rtag;
  logic [SW-1:0] rsize, tsum, cur_new;
  logic [UW-1:0] rfix;
  logic [NW:0]   units;
  logic [UW-1:0] fu;

  assign rd    = oob_q ? 32'd0 : mem_rdata_i;
  assign rtag  = rd[31:24];
  assign rsize = rd[SW-1:0];
  assign rfix  = (rd[31:UW] == '0) ? rd[UW-1:0] : '0;
  assign tsum  = total_q + rsize;
  assign fu    = free_address_i[AW-1:2];

  always_comb begin
    state_d = state_q; ret_d = ret_q; cnt_d = cnt_q; c_d = c_q; start_d = start_q;
    b_d = b_q; a_d = a_q; mb_d = mb_q; l_d = l_q; r_d = r_q; p_d = p_q; n_d = n_q;
    qs_d = qs_q; head_d = head_q; cursor_d = cursor_q; sz_d = sz_q; rest_d = rest_q;
    total_d = total_q; need_d = need_q; idx_d = idx_q; ta_d = ta_q; addr_d = addr_q;
    st_d = st_q; empty_d = empty_q; oob_d = oob_q;
    rd_go = 1'b0; wr_go = 1'b0; ridx = '0; widx = '0; wdat = '0;
    cur_new = '0;
    units = (request_bytes_i == '0) ? (NW+1)'(1)
          : (NW+1)'(({1'b0, request_bytes_i} + 11'd3) >> 2);
    case (state_q)
      S_INIT: begin
        wr_go = 1'b1;
        widx  = IW'(cnt_q);
        wdat  = (cnt_q == '0 || cnt_q == UW'(HeapUnits - 1))
              ? mk_word(TAG_FREE, SW'(HeapUnits)) : 32'd0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == UW'(HeapUnits - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          addr_d = '0;
          st_d   = ST_OK;
          if (!kind_i) begin
            need_d = (units + 2 < (NW+1)'(MinBlockUnits)) ? NW'(MinBlockUnits)
                   : NW'(units + 2);
            if (empty_q) begin
              st_d = ST_NOSPACE; state_d = S_DONE;
            end else begin
              c_d = cursor_q; start_d = cursor_q; cnt_d = '0;
              rd_go = 1'b1; ridx = IW'(cursor_q); state_d = S_A_SZ;
            end
          end else if (free_address_i[1:0] != 2'd0 || fu == '0) begin
            st_d = ST_BADPTR; state_d = S_DONE;
          end else begin
            l_d = fu - 1'b1;
            rd_go = 1'b1; ridx = IW'(fu - 1'b1); state_d = S_F_1;
          end
        end
      end
      S_A_SZ: begin
        if (rsize >= SW'(need_q)) begin
          cursor_d = c_q; sz_d = rsize; state_d = S_A_DEC;
        end else begin
          rd_go = 1'b1; ridx = IW'(c_q) + 1'b1; state_d = S_A_NX;
        end
      end
      S_A_NX: begin
        c_d = rfix; cnt_d = cnt_q + 1'b1;
        rd_go = 1'b1; ridx = IW'(rfix);
        state_d = (rfix == start_q || cnt_q == UW'(HeapUnits - 1)) ? S_A_FIN : S_A_SZ;
      end
      S_A_FIN: begin
        cursor_d = c_q; sz_d = rsize;
        if (rsize < SW'(need_q)) begin
          st_d = ST_NOSPACE; state_d = S_DONE;
        end else begin
          state_d = S_A_DEC;
        end
      end
      S_A_DEC: begin
        wr_go = 1'b1; widx = IW'(c_q);
        if (IW'(sz_q) >= IW'(need_q) + IW'(MinBlockUnits)) begin
          rest_d = sz_q - SW'(need_q);
          idx_d  = IW'(c_q) + IW'(sz_q - SW'(need_q));
          wdat   = mk_word(TAG_FREE, sz_q - SW'(need_q));
          state_d = S_A_W1;
        end else begin
          wdat = mk_word(TAG_USED, sz_q);
          b_d = c_q; ret_d = S_A_T1; state_d = S_CO0;
        end
      end
      S_A_W1: begin
        wr_go = 1'b1; widx = idx_q - 1'b1; wdat = mk_word(TAG_FREE, rest_q);
        state_d = S_A_W2;
      end
      S_A_W2: begin
        wr_go = 1'b1; widx = idx_q; wdat = mk_word(TAG_USED, SW'(need_q));
        state_d = S_A_W3;
      end
      S_A_W3: begin
        wr_go = 1'b1; widx = idx_q + IW'(need_q) - 1'b1;
        wdat = mk_word(TAG_USED, SW'(need_q));
        addr_d = {idx_q[UW-1:0] + 1'b1, 2'b00};
        state_d = S_DONE;
      end
      S_A_T1: begin
        idx_d = IW'(c_q) + IW'(sz_q) - 1'b1;
        rd_go = 1'b1; ridx = IW'(c_q) + IW'(sz_q) - 1'b1; state_d = S_A_T2;
      end
      S_A_T2: begin
        wr_go = 1'b1; widx = idx_q; wdat = mk_word(TAG_USED, rsize);
        addr_d = {c_q + 1'b1, 2'b00};
        state_d = S_DONE;
      end
      S_F_1: begin
        if (rsize < SW'(MinBlockUnits) || IW'(rsize) > IW'(HeapUnits) - IW'(l_q)) begin
          st_d = ST_BADPTR; state_d = S_DONE;
        end else if (rtag == TAG_FREE) begin
          st_d = ST_NOTUSED; state_d = S_DONE;
        end else begin
          sz_d = rsize; ta_d = rtag;
          r_d = UW'(IW'(l_q) + IW'(rsize) - 1'b1);
          rd_go = 1'b1; ridx = IW'(l_q) + IW'(rsize) - 1'b1; state_d = S_F_2;
        end
      end
      S_F_2: begin
        if (ta_q != TAG_USED || rtag != TAG_USED || rsize != sz_q) begin
          st_d = ST_BADPTR; state_d = S_DONE;
        end else begin
          wr_go = 1'b1; widx = IW'(l_q); wdat = mk_word(TAG_FREE, sz_q);
          state_d = S_F_3;
        end
      end
      S_F_3: begin
        wr_go = 1'b1; widx = IW'(r_q); wdat = mk_word(TAG_FREE, sz_q);
        state_d = S_F_4;
      end
      S_F_4: begin
        if (l_q != '0) begin
          rd_go = 1'b1; ridx = IW'(l_q - 1'b1); state_d = S_F_5;
        end else begin
          state_d = S_F_7;
        end
      end
      S_F_5: begin
        if (rtag == TAG_FREE && rsize != '0 && rsize <= SW'(l_q)) begin
          qs_d = rsize[UW-1:0];
          rd_go = 1'b1; ridx = IW'(l_q - rsize[UW-1:0]); state_d = S_F_6;
        end else begin
          state_d = S_F_7;
        end
      end
      S_F_6: begin
        if (rtag == TAG_FREE) begin
          a_d = l_q - qs_q; mb_d = l_q; l_d = l_q - qs_q;
          ret_d = S_F_8; state_d = S_M0;
        end else begin
          state_d = S_F_7;
        end
      end
      S_F_7: begin
        b_d = l_q; ret_d = S_F_8; state_d = S_CI0;
      end
      S_F_8: begin
        if (r_q != UW'(HeapUnits - 1)) begin
          rd_go = 1'b1; ridx = IW'(r_q) + 1'b1; state_d = S_F_9;
        end else begin
          state_d = S_DONE;
        end
      end
      S_F_9: begin
        if (rtag == TAG_FREE) begin
          b_d = r_q + 1'b1; ret_d = S_F_10; state_d = S_CO0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_F_10: begin
        a_d = l_q; mb_d = r_q + 1'b1; ret_d = S_DONE; state_d = S_M0;
      end
      S_CO0: begin
        rd_go = 1'b1; ridx = IW'(b_q) + 2'd2; state_d = S_CO1;
      end
      S_CO1: begin
        p_d = rfix; rd_go = 1'b1; ridx = IW'(b_q) + 1'b1; state_d = S_CO2;
      end
      S_CO2: begin
        if (p_q == b_q) begin
          empty_d = 1'b1; head_d = '0; cursor_d = '0; state_d = ret_q;
        end else begin
          n_d = rfix;
          wr_go = 1'b1; widx = IW'(p_q) + 1'b1; wdat = 32'(rfix);
          state_d = S_CO3;
        end
      end
      S_CO3: begin
        wr_go = 1'b1; widx = IW'(n_q) + 2'd2; wdat = 32'(p_q);
        cur_new = SW'((b_q == cursor_q) ? n_q : cursor_q);
        cursor_d = cur_new[UW-1:0];
        if (b_q == head_q) begin
          head_d = cur_new[UW-1:0];
        end
        state_d = ret_q;
      end
      S_CI0: begin
        if (empty_q) begin
          head_d = b_q; cursor_d = b_q; empty_d = 1'b0;
          wr_go = 1'b1; widx = IW'(b_q) + 1'b1; wdat = 32'(b_q);
          state_d = S_CI5;
        end else begin
          rd_go = 1'b1; ridx = IW'(head_q) + 2'd2; state_d = S_CI1;
        end
      end
      S_CI1: begin
        p_d = rfix;
        wr_go = 1'b1; widx = IW'(b_q) + 1'b1; wdat = 32'(head_q);
        state_d = S_CI2;
      end
      S_CI2: begin
        wr_go = 1'b1; widx = IW'(p_q) + 1'b1; wdat = 32'(b_q); state_d = S_CI3;
      end
      S_CI3: begin
        wr_go = 1'b1; widx = IW'(b_q) + 2'd2; wdat = 32'(p_q); state_d = S_CI4;
      end
      S_CI4: begin
        wr_go = 1'b1; widx = IW'(head_q) + 2'd2; wdat = 32'(b_q);
        head_d = b_q; state_d = ret_q;
      end
      S_CI5: begin
        wr_go = 1'b1; widx = IW'(b_q) + 2'd2; wdat = 32'(b_q); state_d = ret_q;
      end
      S_M0: begin
        rd_go = 1'b1; ridx = IW'(a_q); state_d = S_M1;
      end
      S_M1: begin
        ta_d = rtag; total_d = rsize;
        rd_go = 1'b1; ridx = IW'(mb_q); state_d = S_M2;
      end
      S_M2: begin
        total_d = tsum;
        wr_go = 1'b1; widx = IW'(a_q); wdat = mk_word(ta_q, tsum);
        idx_d = IW'(a_q) + IW'(tsum) - 1'b1;
        state_d = S_M3;
      end
      S_M3: begin
        rd_go = 1'b1; ridx = idx_q; state_d = S_M4;
      end
      S_M4: begin
        wr_go = 1'b1; widx = idx_q; wdat = mk_word(rtag, total_q); state_d = ret_q;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (rd_go) begin
      oob_d = (ridx[IW-1:UW] != '0);
    end
  end

  always_comb begin
    mem_req_o.re    = rd_go;
    mem_req_o.we    = wr_go && (widx[IW-1:UW] == '0);
    mem_req_o.addr  = rd_go ? ridx[UW-1:0] : widx[UW-1:0];
    mem_req_o.wdata = wdat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT; ret_q <= S_DONE; cnt_q <= '0;
      head_q <= '0; cursor_q <= '0; empty_q <= 1'b0;
    end else begin
      state_q <= state_d; ret_q <= ret_d; cnt_q <= cnt_d;
      head_q <= head_d; cursor_q <= cursor_d; empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; start_q <= start_d; b_q <= b_d; a_q <= a_d; mb_q <= mb_d;
    l_q <= l_d; r_q <= r_d; p_q <= p_d; n_q <= n_d; qs_q <= qs_d;
    sz_q <= sz_d; rest_q <= rest_d; total_q <= total_d; need_q <= need_d;
    idx_q <= idx_d; ta_q <= ta_d; addr_q <= addr_d; st_q <= st_d; oob_q <= oob_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign res_valid_o    = (state_q == S_DONE);
  assign user_address_o = addr_q;
  assign status_o       = st_q;

`ifndef SYNTH
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_go && wr_go)) else $error("read and write issued together");
  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0 && cursor_q == '0)) else $error("empty list with live pointers");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> !mem_req_o.we)
    else $error("heap write outside an operation");
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && st_q != ST_OK) |-> addr_q == '0)
    else $error("failed result carries an address");
`endif

endmodule
